// ----- design/pfc_pkg.sv -----
// Shared types, codes and constants for the position frequency counter.
package pfc_pkg;

  // Default sizing of the column store and the counters
  localparam int MAX_POSITIONS_DEF = 1024;
  localparam int COUNT_BITS_DEF    = 32;

  // Fixed field widths
  localparam int NUM_SLOTS   = 5;
  localparam int FIELD_W     = 32;
  localparam int WIDTH_W     = 11;
  localparam int BASE_W      = 8;
  localparam int COL_W       = 10;
  localparam int MODE_W      = 2;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = NUM_SLOTS * FIELD_W;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 11'd1024;

  // Base encodings
  localparam logic [BASE_W-1:0] BASE_A = 8'd1;
  localparam logic [BASE_W-1:0] BASE_C = 8'd2;
  localparam logic [BASE_W-1:0] BASE_G = 8'd4;
  localparam logic [BASE_W-1:0] BASE_T = 8'd8;

  typedef logic [2:0] slot_t;
  localparam slot_t SLOT_A     = 3'd0;
  localparam slot_t SLOT_C     = 3'd1;
  localparam slot_t SLOT_G     = 3'd2;
  localparam slot_t SLOT_T     = 3'd3;
  localparam slot_t SLOT_OTHER = 3'd4;

  typedef enum logic [MODE_W-1:0] {
    MODE_COUNT = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_SPARE = 2'd3
  } mode_t;

  // What the update stage does with an item
  typedef enum logic [1:0] {
    OP_COUNT,
    OP_READ,
    OP_CLEAR,
    OP_ZERO
  } op_t;

  typedef struct packed {
    op_t   op;
    slot_t slot;
    logic  dropped;
  } item_t;

  // Map a base code to its counter slot
  function automatic slot_t base_slot(input logic [BASE_W-1:0] code);
    slot_t s;
    unique case (code)
      BASE_A:  s = SLOT_A;
      BASE_C:  s = SLOT_C;
      BASE_G:  s = SLOT_G;
      BASE_T:  s = SLOT_T;
      default: s = SLOT_OTHER;
    endcase
    return s;
  endfunction

endpackage

// ----- design/position_frequency_counter.sv -----
// Position frequency counter top level: column store, front end and update stage.
//
// Usage:
//   in_*  stream carries one word per item: a base to count at the running
//         position, a column to read, or a column to clear (selected by in_tuser).
//   out_* stream returns one word per input word: the five counts of the
//         column touched and a dropped flag in out_tuser.
//   cfg_* writes the counted width; it is always ready. It is to be written only
//         while no word is in flight; the block itself does not enforce this.
// An accepted word is registered into the update stage and then into the output
// register, which drives out_tvalid. One word is taken per cycle while the output
// drains; the throughput is set by the single read-modify-write of the column
// memory, with same-column words forwarded. Reset (rst_n low, synchronous) clears
// the running position, restores the width to 1024 and then sweeps zeros through
// all MAX_POSITIONS columns, one per cycle; in_tready stays low during that sweep.
// When the receiver stalls, the result is held in the output register, one
// more word may be taken into the update stage, and then in_tready drops.
module position_frequency_counter #(
  parameter int MAX_POSITIONS = pfc_pkg::MAX_POSITIONS_DEF,
  parameter int COUNT_BITS    = pfc_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // base_code [7:0], first_of_sequence [8], column_index [18:9]
  input  logic [pfc_pkg::IN_TDATA_W-1:0]   in_tdata,
  // mode [1:0]
  input  logic [pfc_pkg::MODE_W-1:0]       in_tuser,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // count_a [31:0], count_c [63:32], count_g [95:64], count_t [127:96],
  // count_other [159:128]
  output logic [pfc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // dropped [0]
  output logic                             out_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [pfc_pkg::WIDTH_W-1:0]      cfg_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready
);

  localparam int ADDR_W = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
  localparam int POS_W  = $clog2(MAX_POSITIONS + 1);
  localparam int DATA_W = pfc_pkg::NUM_SLOTS * COUNT_BITS;

  pfc_pkg::item_t    item;
  logic [ADDR_W-1:0] item_addr;
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;
  logic              accept;
  logic              stall;
  logic [ADDR_W-1:0] mem_raddr, upd_waddr, mem_waddr;
  logic              upd_we, mem_we;
  logic [DATA_W-1:0] upd_wdata, mem_wdata, mem_rdata;
  logic [DATA_W-1:0] counts;

  assign cfg_ready = 1'b1;
  assign in_tready = !clearing && !stall;
  assign accept    = in_tvalid && in_tready;

  pfc_front #(
    .MAX_POSITIONS (MAX_POSITIONS),
    .ADDR_W        (ADDR_W),
    .POS_W         (POS_W)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_data          (cfg_data),
    .accept            (accept),
    .mode              (in_tuser),
    .base_code         (in_tdata[7:0]),
    .first_of_sequence (in_tdata[8]),
    .column_index      (in_tdata[18:9]),
    .item              (item),
    .addr              (item_addr),
    .clearing          (clearing),
    .clr_addr          (clr_addr)
  );

  pfc_update #(
    .COUNT_BITS (COUNT_BITS),
    .ADDR_W     (ADDR_W)
  ) u_update (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .new_item    (item),
    .new_addr    (item_addr),
    .mem_rdata   (mem_rdata),
    .out_ready   (out_tready),
    .stall       (stall),
    .mem_raddr   (mem_raddr),
    .mem_we      (upd_we),
    .mem_waddr   (upd_waddr),
    .mem_wdata   (upd_wdata),
    .out_valid   (out_tvalid),
    .out_counts  (counts),
    .out_dropped (out_tuser)
  );

  // Give the clear sweep the write port after reset
  assign mem_we    = clearing || upd_we;
  assign mem_waddr = clearing ? clr_addr : upd_waddr;
  assign mem_wdata = clearing ? '0 : upd_wdata;

  pfc_column_mem #(
    .DEPTH  (MAX_POSITIONS),
    .DATA_W (DATA_W),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Widen each counter into its output field
  always_comb begin
    for (int k = 0; k < pfc_pkg::NUM_SLOTS; k++) begin
      out_tdata[k*pfc_pkg::FIELD_W +: pfc_pkg::FIELD_W] =
        pfc_pkg::FIELD_W'(counts[k*COUNT_BITS +: COUNT_BITS]);
    end
  end

endmodule

// ----- design/pfc_column_mem.sv -----
// Column store: one synchronous memory, one write and one registered read port.
module pfc_column_mem #(
  parameter int DEPTH  = pfc_pkg::MAX_POSITIONS_DEF,
  parameter int DATA_W = pfc_pkg::NUM_SLOTS * pfc_pkg::COUNT_BITS_DEF,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, old data on a same-edge write
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/pfc_front.sv -----
// Front end: width register, running position, item decode and reset clear sweep.
module pfc_front #(
  parameter int MAX_POSITIONS = pfc_pkg::MAX_POSITIONS_DEF,
  parameter int ADDR_W        = 10,
  parameter int POS_W         = 11
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [pfc_pkg::WIDTH_W-1:0]   cfg_data,
  input  logic                          accept,
  input  logic [pfc_pkg::MODE_W-1:0]    mode,
  input  logic [pfc_pkg::BASE_W-1:0]    base_code,
  input  logic                          first_of_sequence,
  input  logic [pfc_pkg::COL_W-1:0]     column_index,
  output pfc_pkg::item_t                item,
  output logic [ADDR_W-1:0]             addr,
  output logic                          clearing,
  output logic [ADDR_W-1:0]             clr_addr
);

  localparam int CMP_W = (POS_W > pfc_pkg::WIDTH_W) ? POS_W : pfc_pkg::WIDTH_W;
  localparam logic [CMP_W-1:0]  MAX_CMP  = CMP_W'(MAX_POSITIONS);
  localparam logic [ADDR_W-1:0] LAST_ADR = ADDR_W'(MAX_POSITIONS - 1);

  logic [pfc_pkg::WIDTH_W-1:0] width_r;
  logic [POS_W-1:0]            pos_r, pos_nxt, pos_cur;
  logic [CMP_W-1:0]            pos_cmp, width_cmp, limit;
  logic [31:0]                 col_wide, pos_wide;
  logic                        col_in_range;
  logic                        clearing_r, clearing_nxt;
  logic [ADDR_W-1:0]           clr_addr_r, clr_addr_nxt;

  // Hold the counted width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= pfc_pkg::WIDTH_RESET;
    end else if (cfg_valid) begin
      width_r <= cfg_data;
    end
  end

  // Resolve the position and the effective width
  always_comb begin
    pos_cur      = first_of_sequence ? '0 : pos_r;
    pos_cmp      = CMP_W'(pos_cur);
    width_cmp    = CMP_W'(width_r);
    limit        = (width_cmp < MAX_CMP) ? width_cmp : MAX_CMP;
    col_wide     = 32'(column_index);
    pos_wide     = 32'(pos_cur);
    col_in_range = col_wide < 32'(MAX_POSITIONS);
  end

  // Decode the word into an operation and a column address
  always_comb begin
    item.op      = pfc_pkg::OP_ZERO;
    item.slot    = pfc_pkg::base_slot(base_code);
    item.dropped = 1'b0;
    addr         = col_wide[ADDR_W-1:0];
    unique case (pfc_pkg::mode_t'(mode))
      pfc_pkg::MODE_COUNT: begin
        addr = pos_wide[ADDR_W-1:0];
        if (pos_cmp >= limit) begin
          item.dropped = 1'b1;
        end else begin
          item.op = pfc_pkg::OP_COUNT;
        end
      end
      pfc_pkg::MODE_READ: begin
        if (col_in_range) item.op = pfc_pkg::OP_READ;
      end
      pfc_pkg::MODE_CLEAR: begin
        if (col_in_range) item.op = pfc_pkg::OP_CLEAR;
      end
      pfc_pkg::MODE_SPARE: begin
        item.op = pfc_pkg::OP_ZERO;
      end
      default: begin
        item.op = pfc_pkg::OP_ZERO;
      end
    endcase
  end

  // Advance the running position on count words, stop at the end of the store
  always_comb begin
    pos_nxt = pos_r;
    if (accept && (pfc_pkg::mode_t'(mode) == pfc_pkg::MODE_COUNT)) begin
      pos_nxt = (pos_cmp < MAX_CMP) ? pos_cur + POS_W'(1) : pos_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // Sweep zeros through the store after reset
  always_comb begin
    clearing_nxt = clearing_r;
    clr_addr_nxt = clr_addr_r;
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == LAST_ADR) clearing_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  assign clearing = clearing_r;
  assign clr_addr = clr_addr_r;

endmodule

// ----- design/pfc_update.sv -----
// Update stage: read-modify-write of one column with forwarding, and the result register.
module pfc_update #(
  parameter int COUNT_BITS = pfc_pkg::COUNT_BITS_DEF,
  parameter int ADDR_W     = 10
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     accept,
  input  pfc_pkg::item_t                           new_item,
  input  logic [ADDR_W-1:0]                        new_addr,
  input  logic [pfc_pkg::NUM_SLOTS*COUNT_BITS-1:0] mem_rdata,
  input  logic                                     out_ready,
  output logic                                     stall,
  output logic [ADDR_W-1:0]                        mem_raddr,
  output logic                                     mem_we,
  output logic [ADDR_W-1:0]                        mem_waddr,
  output logic [pfc_pkg::NUM_SLOTS*COUNT_BITS-1:0] mem_wdata,
  output logic                                     out_valid,
  output logic [pfc_pkg::NUM_SLOTS*COUNT_BITS-1:0] out_counts,
  output logic                                     out_dropped
);

  localparam int DATA_W = pfc_pkg::NUM_SLOTS * COUNT_BITS;

  logic                 s2_valid_r, s2_valid_nxt;
  pfc_pkg::item_t       s2_item_r;
  logic [ADDR_W-1:0]    s2_addr_r;
  logic                 fwd_r, fwd_nxt;
  logic [DATA_W-1:0]    fwd_data_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]    out_counts_r;
  logic                 out_dropped_r;
  logic                 done;
  logic [DATA_W-1:0]    col, upd, res;

  // Finish the held word once the result register is free
  assign stall = s2_valid_r && out_valid_r && !out_ready;
  assign done  = s2_valid_r && !(out_valid_r && !out_ready);

  // Reread the held column while waiting
  assign mem_raddr = accept ? new_addr : s2_addr_r;

  // Take the column, bump the selected counter with saturation
  always_comb begin
    col = fwd_r ? fwd_data_r : mem_rdata;
    upd = col;
    for (int k = 0; k < pfc_pkg::NUM_SLOTS; k++) begin
      if ((int'(s2_item_r.slot) == k) && (col[k*COUNT_BITS +: COUNT_BITS] != '1)) begin
        upd[k*COUNT_BITS +: COUNT_BITS] = col[k*COUNT_BITS +: COUNT_BITS] + COUNT_BITS'(1);
      end
    end
  end

  // Select write-back and result
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = upd;
    res       = '0;
    unique case (s2_item_r.op)
      pfc_pkg::OP_COUNT: begin
        mem_we = done;
        res    = upd;
      end
      pfc_pkg::OP_READ: begin
        res = col;
      end
      pfc_pkg::OP_CLEAR: begin
        mem_we    = done;
        mem_wdata = '0;
        res       = col;
      end
      pfc_pkg::OP_ZERO: begin
        res = '0;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  assign mem_waddr = s2_addr_r;

  // Forward a write that lands on the column just being read
  assign fwd_nxt = accept && mem_we && (new_addr == s2_addr_r);

  always_comb begin
    s2_valid_nxt = s2_valid_r;
    if (accept) begin
      s2_valid_nxt = 1'b1;
    end else if (done) begin
      s2_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s2_valid_r  <= s2_valid_nxt;
      fwd_r       <= fwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    fwd_data_r <= mem_wdata;
    if (accept) begin
      s2_item_r <= new_item;
      s2_addr_r <= new_addr;
    end
    if (done) begin
      out_counts_r  <= res;
      out_dropped_r <= s2_item_r.dropped;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_counts  = out_counts_r;
  assign out_dropped = out_dropped_r;

endmodule

// ----- design/pfc_checker.sv -----
// Port-level checks for the position frequency counter, bound to the top level.
module pfc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [pfc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready
);

  // Hold a result until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // Dropped bases report zero counts
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata == '0))
    else $error("dropped result carries counts");

  // Reset empties the output and blocks input during the clear sweep
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("reset did not idle the ports");

  // A fresh result follows an accepted word through the update stage
  a_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without an accepted word");

endmodule

bind position_frequency_counter pfc_checker u_pfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

// ----- test/testbench.sv -----
// Self-checking testbench for the position frequency counter stream block.
module testbench;

  localparam int MAX_POS     = pfc_pkg::MAX_POSITIONS_DEF;
  localparam int RESET_CYC   = 6;
  localparam int DRAIN_CYC   = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PROBES  = 25;

  // Five counts (a, c, g, t, other from the low end) and the dropped flag
  typedef struct packed {
    logic                                              dropped;
    logic [pfc_pkg::NUM_SLOTS-1:0][pfc_pkg::FIELD_W-1:0] cnt;
  } tally_t;

  typedef struct {
    pfc_pkg::mode_t             mode;
    logic [pfc_pkg::BASE_W-1:0] code;
    logic                       first;
    logic [pfc_pkg::COL_W-1:0]  col;
    bit                         typed;
    tally_t                     want;
  } probe_t;

  logic                            clk;
  logic                            rst_n      = 1'b0;
  logic [pfc_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [pfc_pkg::MODE_W-1:0]      in_tuser   = '0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [pfc_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tuser;
  logic                            out_tvalid;
  logic                            out_tready = 1'b1;
  logic [pfc_pkg::WIDTH_W-1:0]     cfg_data   = '0;
  logic                            cfg_valid  = 1'b0;
  logic                            cfg_ready;

  // Predictor state: column store, running position, counted width
  logic [pfc_pkg::NUM_SLOTS-1:0][pfc_pkg::FIELD_W-1:0] pfm_counts [MAX_POS];
  logic [pfc_pkg::WIDTH_W-1:0] run_pos;
  logic [pfc_pkg::WIDTH_W-1:0] counted_width;

  tally_t expected_tallies [$];
  probe_t probes [NUM_PROBES];
  string  field_names [pfc_pkg::NUM_SLOTS] =
    '{"count_a", "count_c", "count_g", "count_t", "count_other"};

  bit     next_typed;
  tally_t next_want;
  bit     idle_on;
  bit     calm;
  int     stall_left;
  int     err_count;
  int     cycle_count;

  position_frequency_counter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Count, read or clear one column and return what the block should send back
  function automatic tally_t tally_word(input pfc_pkg::mode_t m,
                                        input logic [pfc_pkg::BASE_W-1:0] code,
                                        input logic first,
                                        input logic [pfc_pkg::COL_W-1:0] col);
    tally_t                    r;
    pfc_pkg::slot_t            s;
    int                        lim;
    logic [pfc_pkg::COL_W-1:0] pos_idx;
    r = '0;
    case (m)
      pfc_pkg::MODE_COUNT: begin
        if (first) run_pos = '0;
        lim = (counted_width < MAX_POS) ? int'(counted_width) : MAX_POS;
        if (run_pos >= lim) begin
          r.dropped = 1'b1;
        end else begin
          pos_idx = run_pos[pfc_pkg::COL_W-1:0];
          case (code)
            pfc_pkg::BASE_A: s = pfc_pkg::SLOT_A;
            pfc_pkg::BASE_C: s = pfc_pkg::SLOT_C;
            pfc_pkg::BASE_G: s = pfc_pkg::SLOT_G;
            pfc_pkg::BASE_T: s = pfc_pkg::SLOT_T;
            default:         s = pfc_pkg::SLOT_OTHER;
          endcase
          // Saturate at the top of the counter range
          if (pfm_counts[pos_idx][s] != '1)
            pfm_counts[pos_idx][s] = pfm_counts[pos_idx][s] + pfc_pkg::FIELD_W'(1);
          r.cnt = pfm_counts[pos_idx];
        end
        // Stop at the end of the store, never wrap
        if (run_pos < MAX_POS) run_pos = run_pos + pfc_pkg::WIDTH_W'(1);
      end
      pfc_pkg::MODE_READ: r.cnt = pfm_counts[col];
      pfc_pkg::MODE_CLEAR: begin
        r.cnt = pfm_counts[col];
        pfm_counts[col] = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic tally_t tally_of(input int a, input int c, input int g, input int t,
                                      input int o, input bit d);
    tally_t r;
    r.cnt[pfc_pkg::SLOT_A]     = a;
    r.cnt[pfc_pkg::SLOT_C]     = c;
    r.cnt[pfc_pkg::SLOT_G]     = g;
    r.cnt[pfc_pkg::SLOT_T]     = t;
    r.cnt[pfc_pkg::SLOT_OTHER] = o;
    r.dropped                  = d;
    return r;
  endfunction

  task automatic note_error(input string msg);
    err_count++;
    $display("ERROR cycle %0d: %s", cycle_count, msg);
  endtask

  // Check result words against the oldest prediction, then predict new words
  always @(posedge clk) begin : watch
    tally_t got;
    tally_t want;
    tally_t predicted;
    if (out_tvalid && out_tready) begin
      got.cnt     = out_tdata;
      got.dropped = out_tuser;
      if (expected_tallies.size() == 0) begin
        note_error("result word with nothing pending");
      end else begin
        want = expected_tallies.pop_front();
        for (int k = 0; k < pfc_pkg::NUM_SLOTS; k++)
          if (got.cnt[k] !== want.cnt[k])
            note_error($sformatf("%s got %0d want %0d", field_names[k], got.cnt[k],
                                 want.cnt[k]));
        if (got.dropped !== want.dropped)
          note_error($sformatf("dropped got %b want %b", got.dropped, want.dropped));
      end
    end
    if (in_tvalid && in_tready) begin
      predicted = tally_word(pfc_pkg::mode_t'(in_tuser), in_tdata[7:0], in_tdata[8],
                             in_tdata[18:9]);
      expected_tallies.push_back(next_typed ? next_want : predicted);
    end
    if (cfg_valid && cfg_ready) counted_width = cfg_data;
  end

  // Stall the result side in random bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_tready = 1'b0;
    end else if (!calm && idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = int'($urandom_range(1, 15)) - 1;
      out_tready = 1'b0;
    end else begin
      out_tready = 1'b1;
    end
  end

  // Hold one word on the input until it is taken
  task automatic send_word(input pfc_pkg::mode_t m, input logic [pfc_pkg::BASE_W-1:0] code,
                           input logic first, input logic [pfc_pkg::COL_W-1:0] col,
                           input bit typed = 1'b0, input tally_t want = '0);
    int gap;
    @(negedge clk);
    if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
      gap = int'($urandom_range(1, 15));
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    next_typed = typed;
    next_want  = want;
    in_tdata   = {5'b0, col, first, code};
    in_tuser   = m;
    in_tvalid  = 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid and wait until every pending word has come back
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_tallies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_width(input logic [pfc_pkg::WIDTH_W-1:0] value);
    @(negedge clk);
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Mostly real bases, sometimes any code
  function automatic logic [pfc_pkg::BASE_W-1:0] pick_base();
    case ($urandom_range(0, 4))
      0:       return pfc_pkg::BASE_A;
      1:       return pfc_pkg::BASE_C;
      2:       return pfc_pkg::BASE_G;
      3:       return pfc_pkg::BASE_T;
      default: return pfc_pkg::BASE_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [pfc_pkg::BASE_W-1:0] any_code();
    return pfc_pkg::BASE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [pfc_pkg::COL_W-1:0] any_col();
    return pfc_pkg::COL_W'($urandom_range(0, 1023));
  endfunction

  function automatic logic any_flag();
    return 1'($urandom_range(0, 1));
  endfunction

  // Favor low columns, where the counts pile up
  function automatic logic [pfc_pkg::COL_W-1:0] pick_col();
    if ($urandom_range(0, 3) != 0) return pfc_pkg::COL_W'($urandom_range(0, 31));
    return any_col();
  endfunction

  // One configuration setting followed by random words
  task automatic run_phase(input logic [pfc_pkg::WIDTH_W-1:0] width, input int n_words);
    int sent;
    int pick;
    int len;
    wait_drained();
    write_width(width);
    idle_on = ($urandom_range(0, 3) != 0);
    sent = 0;
    while (sent < n_words) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        // Well-formed sequence: flagged first base, then the rest in order
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 70) : $urandom_range(1, 24);
        if (len > n_words - sent) len = n_words - sent;
        for (int k = 0; k < len; k++)
          send_word(pfc_pkg::MODE_COUNT, pick_base(), k == 0, any_col());
        sent += len;
      end else if (pick < 80) begin
        send_word(pfc_pkg::MODE_READ, any_code(), any_flag(), pick_col());
        sent++;
      end else if (pick < 92) begin
        send_word(pfc_pkg::MODE_CLEAR, any_code(), any_flag(), pick_col());
        sent++;
      end else begin
        send_word(pfc_pkg::mode_t'(2'($urandom_range(0, 3))), any_code(), any_flag(),
                  any_col());
        sent++;
      end
    end
  endtask

  // Give up on a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    foreach (pfm_counts[i]) pfm_counts[i] = '0;
    run_pos       = '0;
    counted_width = pfc_pkg::WIDTH_RESET;
    next_typed    = 1'b0;
    next_want     = '0;
    idle_on       = 1'b1;
    calm          = 1'b0;
    stall_left    = 0;
    err_count     = 0;

    // Directed words at the reset width; typed rows are read straight off the rules
    probes[0]  = '{pfc_pkg::MODE_READ,  8'h00, 1'b0, 10'd0,    1'b1,
                   tally_of(0, 0, 0, 0, 0, 0)};
    probes[1]  = '{pfc_pkg::MODE_READ,  8'hff, 1'b1, 10'd1023, 1'b1,
                   tally_of(0, 0, 0, 0, 0, 0)};
    probes[2]  = '{pfc_pkg::MODE_SPARE, 8'hff, 1'b1, 10'd1023, 1'b1,
                   tally_of(0, 0, 0, 0, 0, 0)};
    probes[3]  = '{pfc_pkg::MODE_COUNT, pfc_pkg::BASE_A, 1'b1, 10'd0, 1'b1,
                   tally_of(1, 0, 0, 0, 0, 0)};
    probes[4]  = '{pfc_pkg::MODE_COUNT, pfc_pkg::BASE_C, 1'b0, 10'd0, 1'b1,
                   tally_of(0, 1, 0, 0, 0, 0)};
    probes[5]  = '{pfc_pkg::MODE_COUNT, pfc_pkg::BASE_G, 1'b0, 10'd0, 1'b1,
                   tally_of(0, 0, 1, 0, 0, 0)};
    probes[6]  = '{pfc_pkg::MODE_COUNT, pfc_pkg::BASE_T, 1'b0, 10'd0, 1'b1,
                   tally_of(0, 0, 0, 1, 0, 0)};
    probes[7]  = '{pfc_pkg::MODE_COUNT, 8'h00, 1'b0, 10'd0,    1'b1,
                   tally_of(0, 0, 0, 0, 1, 0)};
    probes[8]  = '{pfc_pkg::MODE_COUNT, 8'hff, 1'b0, 10'd0,    1'b1,
                   tally_of(0, 0, 0, 0, 1, 0)};
    probes[9]  = '{pfc_pkg::MODE_COUNT, 8'h03, 1'b0, 10'd0,    1'b1,
                   tally_of(0, 0, 0, 0, 1, 0)};
    probes[10] = '{pfc_pkg::MODE_COUNT, 8'h10, 1'b0, 10'd0,    1'b1,
                   tally_of(0, 0, 0, 0, 1, 0)};
    probes[11] = '{pfc_pkg::MODE_COUNT, pfc_pkg::BASE_A, 1'b1, 10'd0, 1'b1,
                   tally_of(2, 0, 0, 0, 0, 0)};
    probes[12] = '{pfc_pkg::MODE_COUNT, pfc_pkg::BASE_A, 1'b1, 10'd0, 1'b1,
                   tally_of(3, 0, 0, 0, 0, 0)};
    probes[13] = '{pfc_pkg::MODE_COUNT, pfc_pkg::BASE_T, 1'b1, 10'd0, 1'b1,
                   tally_of(3, 0, 0, 1, 0, 0)};
    probes[14] = '{pfc_pkg::MODE_COUNT, pfc_pkg::BASE_C, 1'b0, 10'd0, 1'b1,
                   tally_of(0, 2, 0, 0, 0, 0)};
    probes[15] = '{pfc_pkg::MODE_COUNT, 8'h80, 1'b0, 10'd0,    1'b1,
                   tally_of(0, 0, 1, 0, 1, 0)};
    probes[16] = '{pfc_pkg::MODE_SPARE, 8'h00, 1'b0, 10'd0,    1'b1,
                   tally_of(0, 0, 0, 0, 0, 0)};
    probes[17] = '{pfc_pkg::MODE_COUNT, pfc_pkg::BASE_G, 1'b0, 10'd0, 1'b1,
                   tally_of(0, 0, 1, 1, 0, 0)};
    probes[18] = '{pfc_pkg::MODE_READ,  8'h00, 1'b0, 10'd0,    1'b0, '0};
    probes[19] = '{pfc_pkg::MODE_CLEAR, 8'h00, 1'b0, 10'd0,    1'b0, '0};
    probes[20] = '{pfc_pkg::MODE_READ,  8'h00, 1'b0, 10'd0,    1'b1,
                   tally_of(0, 0, 0, 0, 0, 0)};
    probes[21] = '{pfc_pkg::MODE_CLEAR, 8'h00, 1'b0, 10'd0,    1'b1,
                   tally_of(0, 0, 0, 0, 0, 0)};
    probes[22] = '{pfc_pkg::MODE_CLEAR, 8'h00, 1'b0, 10'd1023, 1'b1,
                   tally_of(0, 0, 0, 0, 0, 0)};
    probes[23] = '{pfc_pkg::MODE_READ,  8'h00, 1'b0, 10'd3,    1'b0, '0};
    probes[24] = '{pfc_pkg::MODE_COUNT, pfc_pkg::BASE_A, 1'b1, 10'd0, 1'b1,
                   tally_of(1, 0, 0, 0, 0, 0)};

    // Hold reset, then release; the block clears its store before taking words
    repeat (RESET_CYC) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < NUM_PROBES; i++)
      send_word(probes[i].mode, probes[i].code, probes[i].first, probes[i].col,
                probes[i].typed, probes[i].want);

    // Widths from nothing counted to beyond the store
    run_phase(11'd0, 40);
    run_phase(11'd1, 50);
    run_phase(11'd2047, 55);
    run_phase(11'd5, 55);
    run_phase(pfc_pkg::WIDTH_W'($urandom_range(2, 64)), 60);

    // Walk one sequence past the counted width so the later bases drop
    wait_drained();
    write_width(11'd40);
    for (int k = 0; k < 46; k++)
      send_word(pfc_pkg::MODE_COUNT, pick_base(), k == 0, any_col());
    send_word(pfc_pkg::MODE_READ, 8'h00, 1'b0, 10'd39);
    send_word(pfc_pkg::MODE_READ, 8'h00, 1'b0, 10'd38);
    send_word(pfc_pkg::MODE_CLEAR, 8'h00, 1'b0, 10'd39);
    send_word(pfc_pkg::MODE_READ, 8'h00, 1'b0, 10'd39);
    send_word(pfc_pkg::MODE_COUNT, pfc_pkg::BASE_G, 1'b0, 10'd0);

    run_phase(11'd33, 60);

    // Final stretch at full rate
    calm = 1'b1;
    run_phase(pfc_pkg::WIDTH_W'($urandom_range(1, 1024)), 55);

    wait_drained();
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
